// ----- rtl/fsa_pkg.sv -----
// ----------------------------------------------------------------------------
// fsa_pkg: shared types for the first-free slot allocator
// Operation and status codes, and the beat formats of the request and result
// channels.
// ----------------------------------------------------------------------------
package fsa_pkg;

  // fixed field widths of the channel beats
  localparam int unsigned KindW  = 2;
  localparam int unsigned IdW    = 16;
  localparam int unsigned IndexW = 6;
  localparam int unsigned StatW  = 3;
  localparam int unsigned CountW = 7;

  // operation codes
  typedef enum logic [KindW-1:0] {
    KIND_RESERVE = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_READ    = 2'd2,
    KIND_NOP     = 2'd3
  } kind_e;

  // result status codes
  typedef enum logic [StatW-1:0] {
    ST_OK     = 3'd0,
    ST_FULL   = 3'd1,
    ST_BAD_ID = 3'd2,
    ST_DUP    = 3'd3,
    ST_RANGE  = 3'd4,
    ST_FREE   = 3'd5
  } status_e;

  // request beat
  typedef struct packed {
    kind_e             kind;
    logic [IdW-1:0]    owner_id;
    logic [IndexW-1:0] slot_index;
  } in_t;

  // result beat
  typedef struct packed {
    status_e           status;
    logic [IndexW-1:0] granted_slot;
    logic [IdW-1:0]    slot_owner;
    logic [CountW-1:0] free_count;
    logic [CountW-1:0] used_count;
  } out_t;

endpackage

// ----- rtl/fsa_cell.sv -----
// ----------------------------------------------------------------------------
// fsa_cell: one slot of the rotating owner table
// Holds one owner id and takes its neighbour's id on every shift; a clear
// frees the slot.
// ----------------------------------------------------------------------------
module fsa_cell #(
  parameter int unsigned ID_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               clear_i,
  input  logic               shift_i,
  input  logic [ID_BITS-1:0] nxt_i,
  output logic [ID_BITS-1:0] owner_o
);

  logic [ID_BITS-1:0] owner_q;

  // owner storage, zero means free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owner_q <= '0;
    end else if (clear_i) begin
      owner_q <= '0;
    end else if (shift_i) begin
      owner_q <= nxt_i;
    end
  end

  assign owner_o = owner_q;

endmodule

// ----- rtl/fsa_ring.sv -----
// ----------------------------------------------------------------------------
// fsa_ring: ring of slot cells
// Each shift moves every id one cell towards the head; the head's id comes
// back in at the tail, possibly replaced, so a full turn restores the order.
// ----------------------------------------------------------------------------
module fsa_ring #(
  parameter int unsigned SLOTS   = 64,
  parameter int unsigned ID_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               clear_i,
  input  logic               shift_i,
  input  logic [ID_BITS-1:0] tail_i,
  output logic [ID_BITS-1:0] head_o
);

  logic [ID_BITS-1:0] owner [SLOTS];

  // chain of cells, the last one fed from the tail input
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    logic [ID_BITS-1:0] nxt;
    if (i == SLOTS - 1) begin : g_tail
      assign nxt = tail_i;
    end else begin : g_mid
      assign nxt = owner[i+1];
    end
    fsa_cell #(
      .ID_BITS (ID_BITS)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .clear_i (clear_i),
      .shift_i (shift_i),
      .nxt_i   (nxt),
      .owner_o (owner[i])
    );
  end

  assign head_o = owner[0];

endmodule

// ----- rtl/first_free_slot_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// first_free_slot_allocator_unit: slot table with lowest-free-slot reserve
// The owner table is a ring of SLOTS cells that turns one cell per cycle past
// a single head compare, so every operation that touches the table walks one
// full turn. A read or release walks one turn before its result beat; a reserve
// walks one turn when it finds a duplicate or no free slot and two when it
// writes, since the first turn looks for duplicates and the lowest free slot
// and a second turn stores the id. Requests rejected by the full, zero-id or
// range checks, and kind 3, go straight to the result beat. One request is
// worked on at a time; a new one is taken while the last result beat still waits.
// Writing capacity (saturated to 1..min(SLOTS, 127)) clears the whole table at once.
// ----------------------------------------------------------------------------
module first_free_slot_allocator_unit #(
  parameter int unsigned SLOTS   = 64,
  parameter int unsigned ID_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  fsa_pkg::in_t                   in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output fsa_pkg::out_t                  out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [fsa_pkg::CountW-1:0]     cfg_data_i
);

  import fsa_pkg::*;

  localparam int unsigned IdxW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CmpW    = (IdxW > CountW) ? IdxW : CountW;
  localparam int unsigned CapRst  = (SLOTS < 64) ? SLOTS : 64;
  localparam int unsigned CapMax  = (SLOTS < 127) ? SLOTS : 127;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WRITE,
    S_FINISH
  } state_e;

  state_e              state_q;
  logic [CountW-1:0]   capacity_q;
  logic [CountW-1:0]   occupied_q;
  kind_e               kind_q;
  logic [ID_BITS-1:0]  id_q;
  logic [IndexW-1:0]   idx_q;
  logic [IdxW-1:0]     cnt_q;
  logic                dup_q;
  logic                found_q;
  logic [IdxW-1:0]     free_idx_q;
  logic [ID_BITS-1:0]  owner_q;
  status_e             res_status_q;
  logic                out_valid_q;
  out_t                out_data_q;

  logic                in_accept;
  logic                cfg_accept;
  logic [CountW-1:0]   cap_sat;
  logic [ID_BITS-1:0]  in_id;
  logic                ring_clear;
  logic                ring_shift;
  logic [ID_BITS-1:0]  ring_tail;
  logic [ID_BITS-1:0]  head;
  logic                in_cap;
  logic                at_idx;
  logic                at_free;
  logic                last_step;
  logic                dup_d;
  logic                found_d;
  logic [IdxW-1:0]     free_idx_d;
  logic [ID_BITS-1:0]  owner_d;
  logic                out_free;

  // handshakes, a pending capacity write goes ahead of a request
  assign in_stall_o  = (state_q != S_IDLE) || cfg_valid_i;
  assign cfg_ready_o = (state_q == S_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_accept  = cfg_valid_i && cfg_ready_o;
  assign out_free    = !out_valid_q || !out_stall_i;

  // capacity write saturated into 1..min(SLOTS, 127)
  always_comb begin
    if (cfg_data_i == '0) begin
      cap_sat = CountW'(1);
    end else if (32'(cfg_data_i) > 32'(CapMax)) begin
      cap_sat = CountW'(CapMax);
    end else begin
      cap_sat = cfg_data_i;
    end
  end

  // owner id narrowed or widened to the stored width
  assign in_id = ID_BITS'(in_data_i.owner_id);

  // head compare, slot cnt_q sits at the head during a turn
  assign in_cap    = CmpW'(cnt_q) < CmpW'(capacity_q);
  assign at_idx    = CmpW'(cnt_q) == CmpW'(idx_q);
  assign at_free   = cnt_q == free_idx_q;
  assign last_step = cnt_q == IdxW'(SLOTS - 1);

  // scan bookkeeping, including the head value of this cycle
  always_comb begin
    dup_d      = dup_q;
    found_d    = found_q;
    free_idx_d = free_idx_q;
    owner_d    = owner_q;
    if (state_q == S_SCAN) begin
      if (in_cap && (head == id_q)) begin
        dup_d = 1'b1;
      end
      if (in_cap && (head == '0) && !found_q) begin
        found_d    = 1'b1;
        free_idx_d = cnt_q;
      end
      // only reads and releases report an owner
      if (at_idx && (kind_q != KIND_RESERVE)) begin
        owner_d = head;
      end
    end
  end

  // ring control: the head id re-enters at the tail unless replaced
  always_comb begin
    ring_clear = cfg_accept;
    ring_shift = (state_q == S_SCAN) || (state_q == S_WRITE);
    ring_tail  = head;
    if ((state_q == S_SCAN) && (kind_q == KIND_RELEASE) && at_idx) begin
      ring_tail = '0;
    end else if ((state_q == S_WRITE) && at_free) begin
      ring_tail = id_q;
    end
  end

  fsa_ring #(
    .SLOTS   (SLOTS),
    .ID_BITS (ID_BITS)
  ) u_ring (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (ring_clear),
    .shift_i (ring_shift),
    .tail_i  (ring_tail),
    .head_o  (head)
  );

  // sequencer, counts and result beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      capacity_q   <= CountW'(CapRst);
      occupied_q   <= '0;
      kind_q       <= KIND_NOP;
      id_q         <= '0;
      idx_q        <= '0;
      cnt_q        <= '0;
      dup_q        <= 1'b0;
      found_q      <= 1'b0;
      free_idx_q   <= '0;
      owner_q      <= '0;
      res_status_q <= ST_OK;
      out_valid_q  <= 1'b0;
      out_data_q   <= '0;
    end else begin
      // result beat raised at finish, dropped once taken
      if ((state_q == S_FINISH) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      // configuration write clears the table
      if (cfg_accept) begin
        capacity_q <= cap_sat;
        occupied_q <= '0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            kind_q       <= in_data_i.kind;
            id_q         <= in_id;
            idx_q        <= in_data_i.slot_index;
            cnt_q        <= '0;
            dup_q        <= 1'b0;
            found_q      <= 1'b0;
            free_idx_q   <= '0;
            owner_q      <= '0;
            unique case (in_data_i.kind)
              KIND_RESERVE: begin
                priority if (occupied_q >= capacity_q) begin
                  res_status_q <= ST_FULL;
                  state_q      <= S_FINISH;
                end else if (in_id == '0) begin
                  res_status_q <= ST_BAD_ID;
                  state_q      <= S_FINISH;
                end else begin
                  res_status_q <= ST_OK;
                  state_q      <= S_SCAN;
                end
              end
              KIND_RELEASE, KIND_READ: begin
                if ((CountW'(in_data_i.slot_index) >= capacity_q) ||
                    (32'(in_data_i.slot_index) >= 32'(SLOTS))) begin
                  res_status_q <= ST_RANGE;
                  state_q      <= S_FINISH;
                end else begin
                  res_status_q <= ST_OK;
                  state_q      <= S_SCAN;
                end
              end
              KIND_NOP: begin
                res_status_q <= ST_OK;
                state_q      <= S_FINISH;
              end
              default: begin
                res_status_q <= ST_OK;
                state_q      <= S_FINISH;
              end
            endcase
          end
        end

        S_SCAN: begin
          dup_q      <= dup_d;
          found_q    <= found_d;
          free_idx_q <= free_idx_d;
          owner_q    <= owner_d;
          if (last_step) begin
            cnt_q <= '0;
            if (kind_q == KIND_RESERVE) begin
              priority if (dup_d) begin
                res_status_q <= ST_DUP;
                state_q      <= S_FINISH;
              end else if (!found_d) begin
                res_status_q <= ST_FULL;
                state_q      <= S_FINISH;
              end else begin
                state_q <= S_WRITE;
              end
            end else if (kind_q == KIND_RELEASE) begin
              state_q <= S_FINISH;
              if (owner_d == '0) begin
                res_status_q <= ST_FREE;
              end else begin
                res_status_q <= ST_OK;
                if (occupied_q != '0) begin
                  occupied_q <= occupied_q - CountW'(1);
                end
              end
            end else begin
              res_status_q <= ST_OK;
              state_q      <= S_FINISH;
            end
          end else begin
            cnt_q <= cnt_q + IdxW'(1);
          end
        end

        S_WRITE: begin
          if (last_step) begin
            cnt_q        <= '0;
            occupied_q   <= occupied_q + CountW'(1);
            res_status_q <= ST_OK;
            state_q      <= S_FINISH;
          end else begin
            cnt_q <= cnt_q + IdxW'(1);
          end
        end

        S_FINISH: begin
          if (out_free) begin
            out_data_q.status       <= res_status_q;
            out_data_q.granted_slot <= ((kind_q == KIND_RESERVE) && (res_status_q == ST_OK))
                                       ? IndexW'(free_idx_q) : '0;
            out_data_q.slot_owner   <= IdW'(owner_q);
            out_data_q.free_count   <= capacity_q - occupied_q;
            out_data_q.used_count   <= occupied_q;
            state_q                 <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: first-free slot allocator unit
// Drives request beats and capacity writes into the allocator, keeps its own
// copy of the slot table to predict every result beat, and compares each
// result field by field with the oldest prediction. A directed table comes
// first, then random phases at several capacities, with random idling on both
// the request and the result side.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import fsa_pkg::*;

  localparam int unsigned NumSlots   = 64;
  localparam int unsigned IdleLimit  = 2000;
  localparam int unsigned TailCycles = 140;

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #5 clk_i = ~clk_i;

  // block ports
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  in_t                 in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_t                out_data_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CountW-1:0]   cfg_data_i  = '0;

  first_free_slot_allocator_unit #(
    .SLOTS   (NumSlots),
    .ID_BITS (16)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  // shadow copy of the slot table
  logic [15:0] owner_tbl [NumSlots];
  int unsigned taken_total = 0;
  int unsigned cap_now     = NumSlots;

  // predicted result beats, oldest first
  out_t pending_results [$];

  int unsigned errors        = 0;
  int unsigned requests_sent = 0;
  int unsigned beats_checked = 0;
  int unsigned cap_writes    = 0;
  int unsigned status_tally [6];

  // idling state of the two sides
  bit          tx_burst    = 1'b0;
  bit          rx_burst    = 1'b0;
  int unsigned stall_left  = 0;

  // directed stimulus table
  typedef struct {
    bit          is_cfg;
    logic [6:0]  cap_val;
    in_t         req;
    bit          typed;
    out_t        want;
  } step_row_t;

  step_row_t directed_rows [$];

  initial begin
    foreach (owner_tbl[i]) owner_tbl[i] = '0;
    foreach (status_tally[i]) status_tally[i] = 0;
  end

  // work out the result of one request and update the shadow table
  function automatic out_t allot_outcome(in_t req);
    out_t res;
    bit   found;
    res        = '0;
    res.status = ST_OK;
    found      = 1'b0;
    case (req.kind)
      KIND_RESERVE: begin
        if (taken_total >= cap_now) begin
          res.status = ST_FULL;
        end else if (req.owner_id == '0) begin
          res.status = ST_BAD_ID;
        end else begin
          for (int unsigned i = 0; i < cap_now; i++) begin
            if (owner_tbl[i] == req.owner_id) found = 1'b1;
          end
          if (found) begin
            res.status = ST_DUP;
          end else begin
            res.status = ST_FULL;
            for (int unsigned i = 0; i < cap_now; i++) begin
              if (!found && owner_tbl[i] == '0) begin
                found            = 1'b1;
                owner_tbl[i]     = req.owner_id;
                taken_total++;
                res.status       = ST_OK;
                res.granted_slot = i[IndexW-1:0];
              end
            end
          end
        end
      end
      KIND_RELEASE, KIND_READ: begin
        if (req.slot_index >= cap_now) begin
          res.status = ST_RANGE;
        end else begin
          res.slot_owner = owner_tbl[req.slot_index];
          if (req.kind == KIND_RELEASE) begin
            if (res.slot_owner == '0) begin
              res.status = ST_FREE;
            end else begin
              owner_tbl[req.slot_index] = '0;
              if (taken_total > 0) taken_total--;
            end
          end
        end
      end
      default: ;
    endcase
    res.free_count = CountW'(cap_now - taken_total);
    res.used_count = CountW'(taken_total);
    return res;
  endfunction

  // one line per mismatch, counted always
  task automatic flag_mismatch(string what, int unsigned got, int unsigned want);
    $display("mismatch at %0t: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
    errors++;
  endtask

  // table builders
  function automatic void add_req(kind_e k, logic [15:0] id, logic [5:0] idx);
    step_row_t row;
    row            = '{default: '0};
    row.req.kind   = k;
    row.req.owner_id   = id;
    row.req.slot_index = idx;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_known(kind_e k, logic [15:0] id, logic [5:0] idx,
                                    status_e st, logic [5:0] slot, logic [15:0] owner,
                                    logic [6:0] free_n, logic [6:0] used_n);
    step_row_t row;
    row                   = '{default: '0};
    row.req.kind          = k;
    row.req.owner_id      = id;
    row.req.slot_index    = idx;
    row.typed             = 1'b1;
    row.want.status       = st;
    row.want.granted_slot = slot;
    row.want.slot_owner   = owner;
    row.want.free_count   = free_n;
    row.want.used_count   = used_n;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_cap(logic [6:0] v);
    step_row_t row;
    row         = '{default: '0};
    row.is_cfg  = 1'b1;
    row.cap_val = v;
    directed_rows.push_back(row);
  endfunction

  // send one request beat after a random gap, record its prediction on accept
  task automatic send_beat(in_t req, bit typed, out_t want);
    int unsigned gap;
    out_t        predicted;
    gap = tx_burst ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (in_stall_o);
    predicted = allot_outcome(req);
    if (typed) predicted = want;
    pending_results.push_back(predicted);
    status_tally[int'(predicted.status)]++;
    requests_sent++;
    if (requests_sent % 16 == 0) tx_burst = ($urandom_range(0, 3) == 0);
  endtask

  // write capacity once every result is in and the block has settled
  task automatic set_capacity(logic [6:0] v);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    // saturate into 1..slots and start from an empty table
    cap_now = (v == 0) ? 1 : ((v > NumSlots) ? NumSlots : v);
    foreach (owner_tbl[i]) owner_tbl[i] = '0;
    taken_total = 0;
    cap_writes++;
  endtask

  // random request, mostly in range and with a small id pool for duplicates
  function automatic in_t random_request(int unsigned reserve_pct);
    in_t         r;
    int unsigned pick;
    r    = '0;
    pick = $urandom_range(0, 99);
    if (pick < reserve_pct) begin
      r.kind = KIND_RESERVE;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 45) r.kind = KIND_RELEASE;
      else if (pick < 90) r.kind = KIND_READ;
      else r.kind = KIND_NOP;
    end
    pick = $urandom_range(0, 99);
    if (pick < 3) r.owner_id = '0;
    else if (pick < 30) r.owner_id = 16'($urandom_range(1, 8));
    else r.owner_id = 16'($urandom);
    if ($urandom_range(0, 99) < 80) r.slot_index = 6'($urandom_range(0, cap_now - 1));
    else r.slot_index = 6'($urandom_range(0, 63));
    return r;
  endfunction

  // result side: random stall per beat, check on accept
  always @(posedge clk_i) begin
    out_t        want;
    int unsigned hold;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          flag_mismatch("result beat with nothing pending", 32'(out_data_o.status), 0);
        end else begin
          want = pending_results.pop_front();
          if (out_data_o.status != want.status)
            flag_mismatch("status", 32'(out_data_o.status), 32'(want.status));
          if (out_data_o.granted_slot != want.granted_slot)
            flag_mismatch("granted_slot", 32'(out_data_o.granted_slot),
                          32'(want.granted_slot));
          if (out_data_o.slot_owner != want.slot_owner)
            flag_mismatch("slot_owner", 32'(out_data_o.slot_owner), 32'(want.slot_owner));
          if (out_data_o.free_count != want.free_count)
            flag_mismatch("free_count", 32'(out_data_o.free_count), 32'(want.free_count));
          if (out_data_o.used_count != want.used_count)
            flag_mismatch("used_count", 32'(out_data_o.used_count), 32'(want.used_count));
        end
        beats_checked++;
        if (beats_checked % 16 == 0) rx_burst = ($urandom_range(0, 3) == 0);
        hold        = rx_burst ? 0 : $urandom_range(0, 17);
        stall_left  = hold;
        out_stall_i <= (hold != 0);
      end else if (stall_left > 0) begin
        stall_left--;
        if (stall_left == 0) out_stall_i <= 1'b0;
      end
    end
  end

  // watchdog on cycles without any beat
  int unsigned idle_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("tb: failure");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // stimulus
  initial begin
    int unsigned phase_caps  [8];
    int unsigned phase_items [8];
    int unsigned phase_res   [8];

    phase_caps  = '{64, 2, 127, 9, 0, 33, 64, 0};
    phase_items = '{100, 40, 60, 40, 30, 50, 40, 40};
    phase_res   = '{95, 50, 70, 50, 50, 60, 40, 50};
    phase_caps[7] = $urandom_range(0, 127);

    // whole table at reset capacity: empty reads, id checks, lowest free slot
    add_known(KIND_READ,    16'h0000, 6'd0,  ST_OK,     6'd0, 16'h0000, 7'd64, 7'd0);
    add_known(KIND_RESERVE, 16'h0000, 6'd0,  ST_BAD_ID, 6'd0, 16'h0000, 7'd64, 7'd0);
    add_known(KIND_RESERVE, 16'hFFFF, 6'd0,  ST_OK,     6'd0, 16'h0000, 7'd63, 7'd1);
    add_known(KIND_RESERVE, 16'hFFFF, 6'd0,  ST_DUP,    6'd0, 16'h0000, 7'd63, 7'd1);
    add_req(KIND_RESERVE, 16'h0001, 6'd0);
    add_req(KIND_READ,    16'h0000, 6'd1);
    add_req(KIND_RELEASE, 16'h0000, 6'd0);
    add_req(KIND_RELEASE, 16'h0000, 6'd0);
    add_req(KIND_READ,    16'h0000, 6'd63);
    add_req(KIND_RELEASE, 16'h0000, 6'd63);
    add_req(KIND_NOP,     16'h1234, 6'd5);
    add_req(KIND_RESERVE, 16'h8000, 6'd0);
    add_req(KIND_RESERVE, 16'h7FFF, 6'd0);
    // single slot: full before zero id, index range
    add_cap(7'd1);
    add_known(KIND_RESERVE, 16'hAAAA, 6'd0,  ST_OK,     6'd0, 16'h0000, 7'd0, 7'd1);
    add_known(KIND_RESERVE, 16'h5555, 6'd0,  ST_FULL,   6'd0, 16'h0000, 7'd0, 7'd1);
    add_known(KIND_RESERVE, 16'h0000, 6'd0,  ST_FULL,   6'd0, 16'h0000, 7'd0, 7'd1);
    add_known(KIND_RELEASE, 16'h0000, 6'd1,  ST_RANGE,  6'd0, 16'h0000, 7'd0, 7'd1);
    add_known(KIND_READ,    16'h0000, 6'd63, ST_RANGE,  6'd0, 16'h0000, 7'd0, 7'd1);
    add_known(KIND_READ,    16'h0000, 6'd0,  ST_OK,     6'd0, 16'hAAAA, 7'd0, 7'd1);
    add_known(KIND_RELEASE, 16'h0000, 6'd0,  ST_OK,     6'd0, 16'hAAAA, 7'd1, 7'd0);
    add_known(KIND_RESERVE, 16'h0000, 6'd0,  ST_BAD_ID, 6'd0, 16'h0000, 7'd1, 7'd0);
    // saturation of the capacity write at both ends
    add_cap(7'd0);
    add_known(KIND_READ,    16'h0000, 6'd0,  ST_OK,     6'd0, 16'h0000, 7'd1, 7'd0);
    add_cap(7'd127);
    add_known(KIND_RELEASE, 16'h0000, 6'd63, ST_FREE,   6'd0, 16'h0000, 7'd64, 7'd0);

    // hold reset low before releasing it
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) set_capacity(directed_rows[i].cap_val);
      else send_beat(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
    end

    // random phases, each at its own capacity
    for (int p = 0; p < 8; p++) begin
      set_capacity(7'(phase_caps[p]));
      for (int unsigned n = 0; n < phase_items[p]; n++) begin
        send_beat(random_request(phase_res[p]), 1'b0, '0);
      end
    end
    in_valid_i <= 1'b0;

    // drain, then let the block settle
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    $display("summary: %0d requests, %0d result beats checked, %0d capacity writes",
             requests_sent, beats_checked, cap_writes);
    $display("summary: ok %0d, full %0d, bad id %0d, duplicate %0d, range %0d, free %0d",
             status_tally[0], status_tally[1], status_tally[2], status_tally[3],
             status_tally[4], status_tally[5]);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/fsa_pkg.sv
rtl/fsa_cell.sv
rtl/fsa_ring.sv
rtl/first_free_slot_allocator_unit.sv
dv/testbench.sv
